@@ rtl/pdv_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and helper functions of the pose difference velocity block.
package pdv_pkg;

    // CORDIC iteration count and the counter that covers its full range
    localparam int CORDIC_STEPS     = 24;
    localparam int CORDIC_STEPS_MAX = 32;
    localparam int CORDIC_CNT_W     = $clog2(CORDIC_STEPS_MAX + 1);

    // Angles in Q3.28 radians
    localparam logic signed [33:0] ANG_PI      = 34'sd843314857;
    localparam logic signed [33:0] ANG_TWO_PI  = 34'sd1686629714;
    localparam logic signed [31:0] ANG_HALF_PI = 32'sd421657428;

    // Inverse CORDIC gain in Q0.30 and nanoseconds per second
    localparam logic [31:0] INV_GAIN_Q30 = 32'd652032874;
    localparam logic [31:0] NS_PER_S     = 32'd1000000000;

    // Operation codes of the serial arithmetic unit
    localparam logic [1:0] OP_MUL  = 2'd0;
    localparam logic [1:0] OP_DIV  = 2'd1;
    localparam logic [1:0] OP_SQRT = 2'd2;

    typedef struct packed {
        logic [62:0]        stamp_ns;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] quat_x;
        logic signed [31:0] quat_y;
        logic signed [31:0] quat_z;
        logic signed [31:0] quat_w;
    } pdv_pose_t;

    typedef struct packed {
        logic [62:0]        out_stamp_ns;
        logic signed [31:0] linear_speed;
        logic signed [31:0] roll_rate;
        logic signed [31:0] pitch_rate;
        logic signed [31:0] yaw_rate;
        logic               zero_interval;
    } pdv_rate_t;

    typedef struct packed {
        logic       start;
        logic [1:0] op;
    } pdv_unit_req_t;

    // Arctangent of 2^-i in Q3.28
    function automatic logic signed [31:0] atan_entry(input logic [4:0] idx);
        logic signed [31:0] v;
        case (idx)
            5'd0:    v = 32'sd210828714;
            5'd1:    v = 32'sd124459457;
            5'd2:    v = 32'sd65760959;
            5'd3:    v = 32'sd33381290;
            5'd4:    v = 32'sd16755422;
            5'd5:    v = 32'sd8385879;
            5'd6:    v = 32'sd4193963;
            5'd7:    v = 32'sd2097109;
            5'd8:    v = 32'sd1048571;
            5'd9:    v = 32'sd524287;
            5'd10:   v = 32'sd262144;
            5'd11:   v = 32'sd131072;
            5'd12:   v = 32'sd65536;
            5'd13:   v = 32'sd32768;
            5'd14:   v = 32'sd16384;
            5'd15:   v = 32'sd8192;
            5'd16:   v = 32'sd4096;
            5'd17:   v = 32'sd2048;
            5'd18:   v = 32'sd1024;
            5'd19:   v = 32'sd512;
            5'd20:   v = 32'sd256;
            5'd21:   v = 32'sd128;
            5'd22:   v = 32'sd64;
            5'd23:   v = 32'sd32;
            5'd24:   v = 32'sd16;
            5'd25:   v = 32'sd8;
            5'd26:   v = 32'sd4;
            5'd27:   v = 32'sd2;
            5'd28:   v = 32'sd1;
            default: v = 32'sd0;
        endcase
        return v;
    endfunction

    // Clamp a magnitude with a sign into a 32 bit two's complement rate
    function automatic logic [31:0] sat_rate(input logic [63:0] q, input logic neg);
        logic [31:0] res;
        if (!neg) begin
            res = (q > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
        end
        else begin
            res = (q >= 64'h8000_0000) ? 32'h8000_0000 : (32'd0 - q[31:0]);
        end
        return res;
    endfunction

endpackage

@@ rtl/pdv_serial_unit.sv @@
`timescale 1ns / 1ps
// Shared bit-serial unit: shift-add multiply, restoring divide and digit-by-digit square root.
module pdv_serial_unit
    import pdv_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  pdv_unit_req_t req,
    input  logic [63:0]   opa,
    input  logic [63:0]   opb,
    output logic          done,
    output logic [95:0]   result
);

    logic        busy_reg;
    logic [1:0]  op_reg;
    logic [6:0]  cnt_reg;
    logic [6:0]  last_cnt;
    logic [96:0] p_reg;
    logic [63:0] mcand_reg;
    logic [63:0] quo_reg;
    logic [63:0] rem_reg;
    logic [63:0] rad_reg;
    logic [33:0] srem_reg;
    logic [31:0] root_reg;

    logic [64:0] mul_sum;
    logic [63:0] div_sh;
    logic        div_ge;
    logic [35:0] sq_sh;
    logic [35:0] sq_trial;
    logic        sq_ge;
    logic [35:0] sq_diff;

    // Divide takes one quotient bit per cycle, the others one multiplier bit or root digit
    assign last_cnt = (op_reg == OP_DIV) ? 7'd64 : 7'd32;
    assign done     = busy_reg && (cnt_reg == last_cnt);

    // Step logic of the three operations
    assign mul_sum  = {1'b0, p_reg[95:32]} + (p_reg[0] ? {1'b0, mcand_reg} : 65'd0);
    assign div_sh   = {rem_reg[62:0], quo_reg[63]};
    assign div_ge   = div_sh >= mcand_reg;
    assign sq_sh    = {srem_reg, rad_reg[63:62]};
    assign sq_trial = {2'b00, root_reg, 2'b01};
    assign sq_ge    = sq_sh >= sq_trial;
    assign sq_diff  = sq_sh - sq_trial;

    // Present the finished word of the active operation
    always_comb
    begin
        case (op_reg)
            OP_MUL:  result = p_reg[95:0];
            OP_DIV:  result = {32'd0, quo_reg};
            OP_SQRT: result = {64'd0, root_reg};
            default: result = '0;
        endcase
    end

    // Control: load on start, advance one step a cycle, drop busy when done
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            op_reg   <= OP_MUL;
            cnt_reg  <= '0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            op_reg   <= req.op;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            if (done)
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                cnt_reg <= cnt_reg + 7'd1;
            end
        end
    end

    // Datapath shift registers
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            p_reg     <= {65'd0, opb[31:0]};
            mcand_reg <= (req.op == OP_DIV) ? opb : opa;
            quo_reg   <= opa;
            rem_reg   <= '0;
            rad_reg   <= opa;
            srem_reg  <= '0;
            root_reg  <= '0;
        end
        else if (busy_reg && !done)
        begin
            case (op_reg)
                OP_MUL:
                begin
                    p_reg <= {1'b0, mul_sum, p_reg[31:1]};
                end
                OP_DIV:
                begin
                    rem_reg <= div_ge ? (div_sh - mcand_reg) : div_sh;
                    quo_reg <= {quo_reg[62:0], div_ge};
                end
                OP_SQRT:
                begin
                    srem_reg <= sq_ge ? sq_diff[33:0] : sq_sh[33:0];
                    root_reg <= {root_reg[30:0], sq_ge};
                    rad_reg  <= {rad_reg[61:0], 2'b00};
                end
                default:
                begin
                    p_reg <= p_reg;
                end
            endcase
        end
    end

endmodule

@@ rtl/pdv_cordic.sv @@
`timescale 1ns / 1ps
// Iterative CORDIC vectoring unit: angle and scaled magnitude of a 64 bit vector.
module pdv_cordic
    import pdv_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [63:0] x_in,
    input  logic signed [63:0] y_in,
    output logic               done,
    output logic signed [31:0] angle,
    output logic signed [63:0] mag
);

    logic                    busy_reg;
    logic [CORDIC_CNT_W-1:0] cnt_reg;
    logic signed [63:0]      x_reg;
    logic signed [63:0]      y_reg;
    logic signed [31:0]      z_reg;

    logic                    zero_in;
    logic signed [63:0]      x_load;
    logic signed [63:0]      y_load;
    logic signed [31:0]      z_load;
    logic [4:0]              idx;
    logic signed [63:0]      dx;
    logic signed [63:0]      dy;
    logic signed [31:0]      tab;

    assign zero_in = (x_in == 64'sd0) && (y_in == 64'sd0);
    assign done    = busy_reg && (cnt_reg == CORDIC_CNT_W'(CORDIC_STEPS));
    assign angle   = z_reg;
    assign mag     = x_reg;

    // Pre-rotate by a quarter turn when the vector points left
    always_comb
    begin
        x_load = x_in;
        y_load = y_in;
        z_load = 32'sd0;
        if (x_in < 64'sd0)
        begin
            if (y_in >= 64'sd0)
            begin
                x_load = y_in;
                y_load = 64'sd0 - x_in;
                z_load = ANG_HALF_PI;
            end
            else
            begin
                x_load = 64'sd0 - y_in;
                y_load = x_in;
                z_load = 32'sd0 - ANG_HALF_PI;
            end
        end
    end

    assign idx = cnt_reg[4:0];
    assign dx  = y_reg >>> idx;
    assign dy  = x_reg >>> idx;
    assign tab = atan_entry(idx);

    // Control: a zero vector skips the rotations and reports zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= zero_in ? CORDIC_CNT_W'(CORDIC_STEPS) : '0;
        end
        else if (busy_reg)
        begin
            if (done)
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    // Micro-rotation: turn toward the x axis, one step a cycle
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg <= x_load;
            y_reg <= y_load;
            z_reg <= z_load;
        end
        else if (busy_reg && !done)
        begin
            if (y_reg > 64'sd0)
            begin
                x_reg <= x_reg + dx;
                y_reg <= y_reg - dy;
                z_reg <= z_reg + tab;
            end
            else
            begin
                x_reg <= x_reg - dx;
                y_reg <= y_reg + dy;
                z_reg <= z_reg - tab;
            end
        end
    end

endmodule

@@ rtl/pose_difference_velocity_top.sv @@
`timescale 1ns / 1ps
// Top level of the pose difference velocity block: sequencer, state and output register.
//
//  channel | valid      | stall      | word       | type
//  --------+------------+------------+------------+-----------
//  pose    | pose_valid | pose_stall | pose       | pdv_pose_t
//  rate    | rate_valid | rate_stall | rate       | pdv_rate_t
//
// One pose is worked at a time. The first pose and a repeated stamp skip the rate stage, and
// a gimbal lock skips pitch and yaw. The shared serial unit runs eighteen multiplies, one
// square root and four divides, one bit or digit a cycle.
// Reset clears the sequencer and the stored previous pose. A stalled rate word holds in
// the output register while the next pose is taken and worked.
module pose_difference_velocity_top
    import pdv_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      pose_valid,
    output logic      pose_stall,
    input  pdv_pose_t pose,
    output logic      rate_valid,
    input  logic      rate_stall,
    output pdv_rate_t rate
);

    localparam logic [4:0] S_IDLE       = 5'd0;
    localparam logic [4:0] S_PROD_GO    = 5'd1;
    localparam logic [4:0] S_PROD_WAIT  = 5'd2;
    localparam logic [4:0] S_ROLL_GO    = 5'd3;
    localparam logic [4:0] S_ROLL_WAIT  = 5'd4;
    localparam logic [4:0] S_GAIN_GO    = 5'd5;
    localparam logic [4:0] S_GAIN_WAIT  = 5'd6;
    localparam logic [4:0] S_PITCH_WAIT = 5'd7;
    localparam logic [4:0] S_YAW_WAIT   = 5'd8;
    localparam logic [4:0] S_RATE       = 5'd9;
    localparam logic [4:0] S_SQ_GO      = 5'd10;
    localparam logic [4:0] S_SQ_WAIT    = 5'd11;
    localparam logic [4:0] S_SQRT_GO    = 5'd12;
    localparam logic [4:0] S_SQRT_WAIT  = 5'd13;
    localparam logic [4:0] S_SCALE_GO   = 5'd14;
    localparam logic [4:0] S_SCALE_WAIT = 5'd15;
    localparam logic [4:0] S_DIV_WAIT   = 5'd16;
    localparam logic [4:0] S_OUT        = 5'd17;

    // Quaternion component products
    localparam logic [3:0] PR_XX = 4'd0;
    localparam logic [3:0] PR_YY = 4'd1;
    localparam logic [3:0] PR_ZZ = 4'd2;
    localparam logic [3:0] PR_WW = 4'd3;
    localparam logic [3:0] PR_YZ = 4'd4;
    localparam logic [3:0] PR_WX = 4'd5;
    localparam logic [3:0] PR_XZ = 4'd6;
    localparam logic [3:0] PR_WY = 4'd7;
    localparam logic [3:0] PR_XY = 4'd8;
    localparam logic [3:0] PR_WZ = 4'd9;

    // Position axes and rate lanes
    localparam logic [1:0] AX_X = 2'd0;
    localparam logic [1:0] AX_Y = 2'd1;
    localparam logic [1:0] AX_Z = 2'd2;
    localparam logic [1:0] LN_LIN   = 2'd0;
    localparam logic [1:0] LN_ROLL  = 2'd1;
    localparam logic [1:0] LN_PITCH = 2'd2;
    localparam logic [1:0] LN_YAW   = 2'd3;

    logic [4:0]         state_reg;
    logic [4:0]         state_next;
    pdv_pose_t          pose_reg;
    logic [3:0]         prod_idx_reg;
    logic [1:0]         lane_reg;
    logic signed [63:0] d_acc_reg;
    logic signed [63:0] b_acc_reg;
    logic signed [63:0] x_acc_reg;
    logic signed [63:0] a_acc_reg;
    logic signed [63:0] c_acc_reg;
    logic signed [63:0] y_acc_reg;
    logic signed [31:0] roll_reg;
    logic signed [31:0] pitch_reg;
    logic signed [31:0] yaw_reg;
    logic signed [63:0] mag_reg;
    logic [62:0]        dt_reg;
    logic               dneg_reg;
    logic [63:0]        sum_reg;
    logic [32:0]        dist_reg;
    logic               neg_reg;
    logic [31:0]        lin_reg;
    logic [31:0]        roll_rate_reg;
    logic [31:0]        pitch_rate_reg;
    logic [31:0]        yaw_rate_reg;
    logic               zero_reg;
    pdv_rate_t          out_reg;
    logic               out_valid_reg;
    logic               have_prev_reg;
    logic [62:0]        prev_stamp_reg;
    logic signed [31:0] prev_pos_reg [3];
    logic signed [31:0] prev_ang_reg [3];

    pdv_unit_req_t      unit_req;
    logic [63:0]        unit_opa;
    logic [63:0]        unit_opb;
    logic               unit_done;
    logic [95:0]        unit_result;
    logic               cordic_start;
    logic signed [63:0] cordic_x;
    logic signed [63:0] cordic_y;
    logic               cordic_done;
    logic signed [31:0] cordic_angle;
    logic signed [63:0] cordic_mag;

    logic signed [31:0] opnd_a;
    logic signed [31:0] opnd_b;
    logic [31:0]        abs_a;
    logic [31:0]        abs_b;
    logic               prod_neg;
    logic signed [63:0] prod_s;
    logic signed [63:0] p2;
    logic signed [63:0] c2;
    logic signed [63:0] neg_c2;
    logic signed [63:0] c_abs;
    logic               gimbal;
    logic [63:0]        um;
    logic signed [63:0] gain_r;
    logic signed [31:0] pos_cur;
    logic signed [31:0] pos_prv;
    logic signed [32:0] dp;
    logic [32:0]        dp_abs;
    logic [31:0]        h;
    logic signed [31:0] ang_cur;
    logic signed [31:0] ang_prv;
    logic signed [33:0] df_raw;
    logic signed [33:0] df;
    logic [33:0]        df_mag;
    logic [63:0]        num_mag;
    logic               lane_neg;
    logic               stamp_moved;
    logic               stamp_back;
    logic [63:0]        quo_sh;
    logic [31:0]        rate_val;
    logic               out_free;

    assign pose_stall = (state_reg != S_IDLE);
    assign rate_valid = out_valid_reg;
    assign rate       = out_reg;
    assign out_free   = !out_valid_reg || !rate_stall;

    // Select the quaternion pair of the current product
    always_comb
    begin
        opnd_a = pose_reg.quat_x;
        opnd_b = pose_reg.quat_x;
        case (prod_idx_reg)
            PR_XX:   begin opnd_a = pose_reg.quat_x; opnd_b = pose_reg.quat_x; end
            PR_YY:   begin opnd_a = pose_reg.quat_y; opnd_b = pose_reg.quat_y; end
            PR_ZZ:   begin opnd_a = pose_reg.quat_z; opnd_b = pose_reg.quat_z; end
            PR_WW:   begin opnd_a = pose_reg.quat_w; opnd_b = pose_reg.quat_w; end
            PR_YZ:   begin opnd_a = pose_reg.quat_y; opnd_b = pose_reg.quat_z; end
            PR_WX:   begin opnd_a = pose_reg.quat_w; opnd_b = pose_reg.quat_x; end
            PR_XZ:   begin opnd_a = pose_reg.quat_x; opnd_b = pose_reg.quat_z; end
            PR_WY:   begin opnd_a = pose_reg.quat_w; opnd_b = pose_reg.quat_y; end
            PR_XY:   begin opnd_a = pose_reg.quat_x; opnd_b = pose_reg.quat_y; end
            PR_WZ:   begin opnd_a = pose_reg.quat_w; opnd_b = pose_reg.quat_z; end
            default: begin opnd_a = pose_reg.quat_x; opnd_b = pose_reg.quat_x; end
        endcase
    end

    assign abs_a    = opnd_a[31] ? (32'd0 - opnd_a) : opnd_a;
    assign abs_b    = opnd_b[31] ? (32'd0 - opnd_b) : opnd_b;
    assign prod_neg = opnd_a[31] ^ opnd_b[31];
    assign prod_s   = prod_neg ? (64'sd0 - $signed(unit_result[63:0]))
                               : $signed(unit_result[63:0]);
    assign p2       = prod_s >>> 2;

    // Pitch terms: gimbal test and magnitude scaled by the inverse gain
    assign c2     = c_acc_reg <<< 1;
    assign neg_c2 = 64'sd0 - c2;
    assign c_abs  = c2[63] ? neg_c2 : c2;
    assign gimbal = c_abs >= d_acc_reg;
    assign um     = mag_reg[63] ? 64'd0 : mag_reg;
    assign gain_r = $signed(unit_result[93:30]);

    // Position difference of the current axis, halved magnitude
    always_comb
    begin
        pos_cur = pose_reg.pos_x;
        pos_prv = prev_pos_reg[0];
        case (lane_reg)
            AX_X:    begin pos_cur = pose_reg.pos_x; pos_prv = prev_pos_reg[0]; end
            AX_Y:    begin pos_cur = pose_reg.pos_y; pos_prv = prev_pos_reg[1]; end
            AX_Z:    begin pos_cur = pose_reg.pos_z; pos_prv = prev_pos_reg[2]; end
            default: begin pos_cur = pose_reg.pos_x; pos_prv = prev_pos_reg[0]; end
        endcase
    end

    assign dp     = $signed({pos_cur[31], pos_cur}) - $signed({pos_prv[31], pos_prv});
    assign dp_abs = dp[32] ? (33'd0 - dp) : dp;
    assign h      = dp_abs[32:1];

    // Angle difference of the current lane, wrapped once into plus or minus pi
    always_comb
    begin
        ang_cur = roll_reg;
        ang_prv = prev_ang_reg[0];
        case (lane_reg)
            LN_ROLL:  begin ang_cur = roll_reg;  ang_prv = prev_ang_reg[0]; end
            LN_PITCH: begin ang_cur = pitch_reg; ang_prv = prev_ang_reg[1]; end
            LN_YAW:   begin ang_cur = yaw_reg;   ang_prv = prev_ang_reg[2]; end
            default:  begin ang_cur = roll_reg;  ang_prv = prev_ang_reg[0]; end
        endcase
    end

    assign df_raw = 34'(ang_cur) - 34'(ang_prv);

    always_comb
    begin
        if (df_raw > ANG_PI)
        begin
            df = df_raw - ANG_TWO_PI;
        end
        else if (df_raw < (34'sd0 - ANG_PI))
        begin
            df = df_raw + ANG_TWO_PI;
        end
        else
        begin
            df = df_raw;
        end
    end

    assign df_mag   = df[33] ? (34'd0 - df) : df;
    assign num_mag  = (lane_reg == LN_LIN) ? {31'd0, dist_reg} : {30'd0, df_mag};
    assign lane_neg = (lane_reg == LN_LIN) ? dneg_reg : (df[33] ^ dneg_reg);

    assign stamp_moved = have_prev_reg && (pose_reg.stamp_ns != prev_stamp_reg);
    assign stamp_back  = pose_reg.stamp_ns < prev_stamp_reg;
    assign quo_sh      = (lane_reg == LN_LIN) ? unit_result[63:0]
                                              : {12'd0, unit_result[63:12]};
    assign rate_val    = sat_rate(quo_sh, neg_reg);

    // Issue operations to the serial unit
    always_comb
    begin
        unit_req.start = 1'b0;
        unit_req.op    = OP_MUL;
        unit_opa       = {32'd0, abs_a};
        unit_opb       = {32'd0, abs_b};
        case (state_reg)
            S_PROD_GO:
            begin
                unit_req.start = 1'b1;
            end
            S_GAIN_GO:
            begin
                unit_req.start = 1'b1;
                unit_opa       = um;
                unit_opb       = {32'd0, INV_GAIN_Q30};
            end
            S_SQ_GO:
            begin
                unit_req.start = 1'b1;
                unit_opa       = {32'd0, h};
                unit_opb       = {32'd0, h};
            end
            S_SQRT_GO:
            begin
                unit_req.start = 1'b1;
                unit_req.op    = OP_SQRT;
                unit_opa       = sum_reg;
            end
            S_SCALE_GO:
            begin
                unit_req.start = 1'b1;
                unit_opa       = num_mag;
                unit_opb       = {32'd0, NS_PER_S};
            end
            S_SCALE_WAIT:
            begin
                unit_req.start = unit_done;
                unit_req.op    = OP_DIV;
                unit_opa       = unit_result[63:0];
                unit_opb       = {1'b0, dt_reg};
            end
            default:
            begin
                unit_req.start = 1'b0;
            end
        endcase
    end

    // Issue the three angle extractions to the CORDIC unit
    always_comb
    begin
        cordic_start = 1'b0;
        cordic_x     = b_acc_reg >>> 4;
        cordic_y     = a_acc_reg >>> 3;
        case (state_reg)
            S_ROLL_GO:
            begin
                cordic_start = (d_acc_reg != 64'sd0);
            end
            S_GAIN_WAIT:
            begin
                cordic_start = unit_done;
                cordic_x     = gain_r;
                cordic_y     = neg_c2 >>> 4;
            end
            S_PITCH_WAIT:
            begin
                cordic_start = cordic_done;
                cordic_x     = x_acc_reg >>> 4;
                cordic_y     = y_acc_reg >>> 3;
            end
            default:
            begin
                cordic_start = 1'b0;
            end
        endcase
    end

    pdv_serial_unit u_unit (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (unit_req),
        .opa    (unit_opa),
        .opb    (unit_opb),
        .done   (unit_done),
        .result (unit_result)
    );

    pdv_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cordic_start),
        .x_in  (cordic_x),
        .y_in  (cordic_y),
        .done  (cordic_done),
        .angle (cordic_angle),
        .mag   (cordic_mag)
    );

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:       if (pose_valid) state_next = S_PROD_GO;
            S_PROD_GO:    state_next = S_PROD_WAIT;
            S_PROD_WAIT:
            begin
                if (unit_done)
                begin
                    state_next = (prod_idx_reg == PR_WZ) ? S_ROLL_GO : S_PROD_GO;
                end
            end
            S_ROLL_GO:    state_next = (d_acc_reg == 64'sd0) ? S_RATE : S_ROLL_WAIT;
            S_ROLL_WAIT:
            begin
                if (cordic_done)
                begin
                    state_next = gimbal ? S_RATE : S_GAIN_GO;
                end
            end
            S_GAIN_GO:    state_next = S_GAIN_WAIT;
            S_GAIN_WAIT:  if (unit_done) state_next = S_PITCH_WAIT;
            S_PITCH_WAIT: if (cordic_done) state_next = S_YAW_WAIT;
            S_YAW_WAIT:   if (cordic_done) state_next = S_RATE;
            S_RATE:       state_next = stamp_moved ? S_SQ_GO : S_OUT;
            S_SQ_GO:      state_next = S_SQ_WAIT;
            S_SQ_WAIT:
            begin
                if (unit_done)
                begin
                    state_next = (lane_reg == AX_Z) ? S_SQRT_GO : S_SQ_GO;
                end
            end
            S_SQRT_GO:    state_next = S_SQRT_WAIT;
            S_SQRT_WAIT:  if (unit_done) state_next = S_SCALE_GO;
            S_SCALE_GO:   state_next = S_SCALE_WAIT;
            S_SCALE_WAIT: if (unit_done) state_next = S_DIV_WAIT;
            S_DIV_WAIT:
            begin
                if (unit_done)
                begin
                    state_next = (lane_reg == LN_YAW) ? S_OUT : S_SCALE_GO;
                end
            end
            S_OUT:        if (out_free) state_next = S_IDLE;
            default:      state_next = S_IDLE;
        endcase
    end

    // Control registers: state, counters, output valid, stored previous pose
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            prod_idx_reg   <= PR_XX;
            lane_reg       <= AX_X;
            out_valid_reg  <= 1'b0;
            have_prev_reg  <= 1'b0;
            prev_stamp_reg <= '0;
            for (int i = 0; i < 3; i++)
            begin
                prev_pos_reg[i] <= '0;
                prev_ang_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;

            // advance the product and lane counters
            if (state_reg == S_IDLE)
            begin
                prod_idx_reg <= PR_XX;
            end
            else if (state_reg == S_PROD_WAIT && unit_done)
            begin
                prod_idx_reg <= prod_idx_reg + 4'd1;
            end

            if (state_reg == S_RATE || state_reg == S_SQRT_WAIT)
            begin
                lane_reg <= AX_X;
            end
            else if ((state_reg == S_SQ_WAIT || state_reg == S_DIV_WAIT) && unit_done)
            begin
                lane_reg <= lane_reg + 2'd1;
            end

            // hold the result word until taken, then take the next
            if (state_reg == S_OUT && out_free)
            begin
                out_valid_reg   <= 1'b1;
                have_prev_reg   <= 1'b1;
                prev_stamp_reg  <= pose_reg.stamp_ns;
                prev_pos_reg[0] <= pose_reg.pos_x;
                prev_pos_reg[1] <= pose_reg.pos_y;
                prev_pos_reg[2] <= pose_reg.pos_z;
                prev_ang_reg[0] <= roll_reg;
                prev_ang_reg[1] <= pitch_reg;
                prev_ang_reg[2] <= yaw_reg;
            end
            else if (!rate_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                pose_reg  <= pose;
                d_acc_reg <= '0;
                b_acc_reg <= '0;
                x_acc_reg <= '0;
                a_acc_reg <= '0;
                c_acc_reg <= '0;
                y_acc_reg <= '0;
                sum_reg   <= '0;
            end
            S_PROD_WAIT:
            begin
                if (unit_done)
                begin
                    case (prod_idx_reg)
                        PR_XX:
                        begin
                            d_acc_reg <= d_acc_reg + p2;
                            b_acc_reg <= b_acc_reg - p2;
                            x_acc_reg <= x_acc_reg + p2;
                        end
                        PR_YY:
                        begin
                            d_acc_reg <= d_acc_reg + p2;
                            b_acc_reg <= b_acc_reg - p2;
                            x_acc_reg <= x_acc_reg - p2;
                        end
                        PR_ZZ:
                        begin
                            d_acc_reg <= d_acc_reg + p2;
                            b_acc_reg <= b_acc_reg + p2;
                            x_acc_reg <= x_acc_reg - p2;
                        end
                        PR_WW:
                        begin
                            d_acc_reg <= d_acc_reg + p2;
                            b_acc_reg <= b_acc_reg + p2;
                            x_acc_reg <= x_acc_reg + p2;
                        end
                        PR_YZ, PR_WX: a_acc_reg <= a_acc_reg + p2;
                        PR_XZ:        c_acc_reg <= c_acc_reg + p2;
                        PR_WY:        c_acc_reg <= c_acc_reg - p2;
                        PR_XY, PR_WZ: y_acc_reg <= y_acc_reg + p2;
                        default:      d_acc_reg <= d_acc_reg;
                    endcase
                end
            end
            S_ROLL_GO:
            begin
                // a zero quaternion gives zero angles
                roll_reg  <= '0;
                pitch_reg <= '0;
                yaw_reg   <= '0;
            end
            S_ROLL_WAIT:
            begin
                if (cordic_done)
                begin
                    roll_reg <= cordic_angle;
                    mag_reg  <= cordic_mag;
                    if (gimbal)
                    begin
                        pitch_reg <= c2[63] ? ANG_HALF_PI : (32'sd0 - ANG_HALF_PI);
                        yaw_reg   <= '0;
                    end
                end
            end
            S_PITCH_WAIT:
            begin
                if (cordic_done) pitch_reg <= cordic_angle;
            end
            S_YAW_WAIT:
            begin
                if (cordic_done) yaw_reg <= cordic_angle;
            end
            S_RATE:
            begin
                dneg_reg       <= stamp_back;
                dt_reg         <= stamp_back ? (prev_stamp_reg - pose_reg.stamp_ns)
                                             : (pose_reg.stamp_ns - prev_stamp_reg);
                zero_reg       <= !stamp_moved;
                lin_reg        <= '0;
                roll_rate_reg  <= '0;
                pitch_rate_reg <= '0;
                yaw_rate_reg   <= '0;
            end
            S_SQ_WAIT:
            begin
                if (unit_done) sum_reg <= sum_reg + unit_result[63:0];
            end
            S_SQRT_WAIT:
            begin
                if (unit_done) dist_reg <= {unit_result[31:0], 1'b0};
            end
            S_SCALE_GO:
            begin
                neg_reg <= lane_neg;
            end
            S_DIV_WAIT:
            begin
                if (unit_done)
                begin
                    case (lane_reg)
                        LN_LIN:   lin_reg        <= rate_val;
                        LN_ROLL:  roll_rate_reg  <= rate_val;
                        LN_PITCH: pitch_rate_reg <= rate_val;
                        LN_YAW:   yaw_rate_reg   <= rate_val;
                        default:  lin_reg        <= rate_val;
                    endcase
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    out_reg.out_stamp_ns  <= pose_reg.stamp_ns;
                    out_reg.linear_speed  <= lin_reg;
                    out_reg.roll_rate     <= roll_rate_reg;
                    out_reg.pitch_rate    <= pitch_rate_reg;
                    out_reg.yaw_rate      <= yaw_rate_reg;
                    out_reg.zero_interval <= zero_reg;
                end
            end
            default:
            begin
                pose_reg <= pose_reg;
            end
        endcase
    end

endmodule

@@ dv/pose_difference_velocity_top_test.sv @@
`timescale 1ns / 1ps
// Self-checking testbench of the pose difference velocity block: stimulus, predictor, checker.
module pose_difference_velocity_top_test;
    import pdv_pkg::*;

    localparam int  ITEM_COUNT   = 750;
    localparam int  QUIET_ITEMS  = 100;
    localparam int  DRAIN_CYCLES = 1500;
    localparam longint Q_ONE     = 64'sd1073741824;

    typedef struct {
        pdv_pose_t word;
        bit        wait_drain;
    } pose_job_t;

    logic      clk;
    logic      rst_n;
    logic      pose_valid;
    logic      pose_stall;
    pdv_pose_t pose;
    logic      rate_valid;
    logic      rate_stall;
    pdv_rate_t rate;

    pose_job_t pose_jobs[$];
    pdv_rate_t rate_expected[$];
    int        mismatch_count;
    int        pose_accepted;
    int        rate_received;
    int        zero_rates_seen;
    bit        quiet;

    // Predictor copy of the stored previous pose
    bit          last_valid;
    logic [62:0] last_stamp;
    int          last_pos[3];
    int          last_ang[3];

    longint arctan_step[32] = '{
        210828714, 124459457, 65760959, 33381290, 16755422, 8385879, 4193963,
        2097109, 1048571, 524287, 262144, 131072, 65536, 32768, 16384, 8192,
        4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2, 1, 0, 0, 0};

    pose_difference_velocity_top i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .pose_valid (pose_valid),
        .pose_stall (pose_stall),
        .pose       (pose),
        .rate_valid (rate_valid),
        .rate_stall (rate_stall),
        .rate       (rate)
    );

    always #10 clk = ~clk;

    // CORDIC vectoring: angle of (x, y) in Q3.28, magnitude scaled by the gain
    function automatic longint cordic_angle(input longint x0, input longint y0,
                                            output longint mag);
        longint x;
        longint y;
        longint z;
        longint t;
        longint dx;
        longint dy;
        x = x0;
        y = y0;
        z = 0;
        if (x == 0 && y == 0) begin
            mag = 0;
            return 0;
        end
        if (x < 0) begin
            t = x;
            if (y >= 0) begin
                x = y;
                y = -t;
                z = longint'(ANG_HALF_PI);
            end
            else begin
                x = -y;
                y = t;
                z = -longint'(ANG_HALF_PI);
            end
        end
        for (int i = 0; i < CORDIC_STEPS && i < 32; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0) begin
                x = x + dx;
                y = y - dy;
                z = z + arctan_step[i];
            end
            else begin
                x = x - dx;
                y = y + dy;
                z = z - arctan_step[i];
            end
        end
        mag = x;
        return z;
    endfunction

    // Quaternion to roll, pitch, yaw in ZYX order
    task automatic quat_to_euler(input pdv_pose_t p, output int ang[3]);
        longint qx, qy, qz, qw;
        longint pxx, pyy, pzz, pww, pxy, pxz, pyz, pwx, pwy, pwz;
        longint d, a, b, c, yy, xx, m, unused, cabs;
        longint roll, pitch, yaw;
        logic [63:0] um, r;
        qx = longint'(p.quat_x);
        qy = longint'(p.quat_y);
        qz = longint'(p.quat_z);
        qw = longint'(p.quat_w);
        pxx = (qx * qx) >>> 2;
        pyy = (qy * qy) >>> 2;
        pzz = (qz * qz) >>> 2;
        pww = (qw * qw) >>> 2;
        pxy = (qx * qy) >>> 2;
        pxz = (qx * qz) >>> 2;
        pyz = (qy * qz) >>> 2;
        pwx = (qw * qx) >>> 2;
        pwy = (qw * qy) >>> 2;
        pwz = (qw * qz) >>> 2;
        d  = pxx + pyy + pzz + pww;
        a  = 2 * (pyz + pwx);
        b  = pww - pxx - pyy + pzz;
        c  = 2 * (pxz - pwy);
        yy = 2 * (pxy + pwz);
        xx = pww + pxx - pyy - pzz;
        if (d == 0) begin
            ang[0] = 0;
            ang[1] = 0;
            ang[2] = 0;
            return;
        end
        roll = cordic_angle(b >>> 4, a >>> 4, m);
        cabs = (c < 0) ? -c : c;
        if (cabs >= d) begin
            pitch = (c < 0) ? longint'(ANG_HALF_PI) : -longint'(ANG_HALF_PI);
            yaw   = 0;
        end
        else begin
            um = (m < 0) ? 64'd0 : m;
            r  = (um >> 30) * 64'(INV_GAIN_Q30)
               + (((um & 64'h3FFF_FFFF) * 64'(INV_GAIN_Q30)) >> 30);
            pitch = cordic_angle(longint'(r), (-c) >>> 4, unused);
            yaw   = cordic_angle(xx >>> 4, yy >>> 4, unused);
        end
        ang[0] = int'(roll);
        ang[1] = int'(pitch);
        ang[2] = int'(yaw);
    endtask

    function automatic logic [63:0] root64(input logic [63:0] v0);
        logic [63:0] v, res, bitv;
        v = v0;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic logic [31:0] clamp_rate(input logic [63:0] q, input bit neg);
        if (!neg) return (q > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
        if (q >= 64'h8000_0000) return 32'h8000_0000;
        return 32'd0 - q[31:0];
    endfunction

    // Work out the rate word of one pose and advance the stored previous pose
    task automatic predict_rate(input pdv_pose_t p, output pdv_rate_t res);
        int          ang[3];
        int          pos[3];
        bit          dneg;
        logic [63:0] dt, sum, h, span, mag;
        longint      dp, df;
        pos[0] = p.pos_x;
        pos[1] = p.pos_y;
        pos[2] = p.pos_z;
        quat_to_euler(p, ang);
        res = '0;
        res.out_stamp_ns = p.stamp_ns;
        if (last_valid && p.stamp_ns != last_stamp) begin
            dneg = p.stamp_ns < last_stamp;
            dt = dneg ? 64'(last_stamp - p.stamp_ns) : 64'(p.stamp_ns - last_stamp);
            sum = 0;
            for (int i = 0; i < 3; i++) begin
                dp = longint'(pos[i]) - longint'(last_pos[i]);
                h = ((dp < 0) ? -dp : dp) >> 1;
                sum = sum + h * h;
            end
            span = 2 * root64(sum);
            res.linear_speed = clamp_rate(span * 64'(NS_PER_S) / dt, dneg);
            for (int i = 0; i < 3; i++) begin
                df = longint'(ang[i]) - longint'(last_ang[i]);
                if (df > longint'(ANG_PI)) df = df - longint'(ANG_TWO_PI);
                else if (df < -longint'(ANG_PI)) df = df + longint'(ANG_TWO_PI);
                mag = (df < 0) ? -df : df;
                mag = (mag * 64'(NS_PER_S) / dt) >> 12;
                case (i)
                    0: res.roll_rate  = clamp_rate(mag, (df < 0) != dneg);
                    1: res.pitch_rate = clamp_rate(mag, (df < 0) != dneg);
                    default: res.yaw_rate = clamp_rate(mag, (df < 0) != dneg);
                endcase
            end
            res.zero_interval = 1'b0;
        end
        else begin
            res.zero_interval = 1'b1;
        end
        last_valid = 1;
        last_stamp = p.stamp_ns;
        for (int i = 0; i < 3; i++) begin
            last_pos[i] = pos[i];
            last_ang[i] = ang[i];
        end
    endtask

    function automatic logic signed [31:0] rand_quat();
        return 32'(longint'($urandom_range(32'h8000_0000, 0)) - Q_ONE);
    endfunction

    function automatic pdv_pose_t make_pose(input logic [62:0] stamp, input int px,
                                            input int py, input int pz, input int qx,
                                            input int qy, input int qz, input int qw);
        pdv_pose_t p;
        p.stamp_ns = stamp;
        p.pos_x  = px;
        p.pos_y  = py;
        p.pos_z  = pz;
        p.quat_x = qx;
        p.quat_y = qy;
        p.quat_z = qz;
        p.quat_w = qw;
        return p;
    endfunction

    task automatic queue_pose(input pdv_pose_t p, input bit hold);
        pose_job_t j;
        j.word = p;
        j.wait_drain = hold;
        pose_jobs.push_back(j);
    endtask

    // Driver: present pending words with random idle bursts
    int pose_gap;
    always @(posedge clk or negedge rst_n) begin
        pdv_rate_t exp_word;
        if (!rst_n) begin
            pose_valid <= 1'b0;
            pose       <= '0;
            pose_gap   = 0;
        end
        else begin
            if (pose_valid && !pose_stall) begin
                predict_rate(pose, exp_word);
                rate_expected.push_back(exp_word);
                pose_accepted++;
            end
            if (!pose_valid || !pose_stall) begin
                if (pose_jobs.size() <= QUIET_ITEMS) quiet = 1;
                if (pose_gap > 0) begin
                    pose_gap--;
                    pose_valid <= 1'b0;
                end
                else if (!quiet && $urandom_range(7, 0) == 0) begin
                    pose_gap = $urandom_range(9, 0);
                    pose_valid <= 1'b0;
                end
                else if (pose_jobs.size() != 0 && !(pose_jobs[0].wait_drain &&
                         (rate_expected.size() != 0 || (pose_valid && !pose_stall)))) begin
                    pose       <= pose_jobs[0].word;
                    pose_valid <= 1'b1;
                    void'(pose_jobs.pop_front());
                end
                else begin
                    pose_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each rate word against the oldest prediction, stall in bursts
    int rate_hold;
    always @(posedge clk or negedge rst_n) begin
        pdv_rate_t e;
        if (!rst_n) begin
            rate_stall <= 1'b0;
            rate_hold  = 0;
        end
        else begin
            if (rate_valid && !rate_stall) begin
                rate_received++;
                if (rate_expected.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: unexpected rate word %h", $time, rate);
                end
                else begin
                    e = rate_expected.pop_front();
                    if (rate.zero_interval) zero_rates_seen++;
                    if (rate.out_stamp_ns !== e.out_stamp_ns || rate.linear_speed !== e.linear_speed
                        || rate.roll_rate !== e.roll_rate || rate.pitch_rate !== e.pitch_rate
                        || rate.yaw_rate !== e.yaw_rate
                        || rate.zero_interval !== e.zero_interval) begin
                        mismatch_count++;
                        $display("%0t: mismatch stamp %h/%h speed %h/%h roll %h/%h",
                                 $time, e.out_stamp_ns, rate.out_stamp_ns, e.linear_speed,
                                 rate.linear_speed, e.roll_rate, rate.roll_rate);
                        $display("    pitch %h/%h yaw %h/%h zero %b/%b (expected/actual)",
                                 e.pitch_rate, rate.pitch_rate, e.yaw_rate, rate.yaw_rate,
                                 e.zero_interval, rate.zero_interval);
                    end
                end
            end
            if (rate_hold > 0) begin
                rate_hold--;
                rate_stall <= 1'b1;
            end
            else if (!quiet && $urandom_range(5, 0) == 0) begin
                rate_hold = $urandom_range(9, 0);
                rate_stall <= 1'b1;
            end
            else begin
                rate_stall <= 1'b0;
            end
        end
    end

    // Stimulus and end of run
    initial begin
        logic [62:0] stamp;
        int px, py, pz, kind;
        clk = 0;
        rst_n = 0;
        quiet = 0;
        mismatch_count = 0;
        pose_accepted = 0;
        rate_received = 0;
        zero_rates_seen = 0;
        last_valid = 0;
        last_stamp = 0;
        for (int i = 0; i < 3; i++) begin
            last_pos[i] = 0;
            last_ang[i] = 0;
        end

        // Directed: first pose, equal stamps, backwards, extremes, zero quat, gimbal lock
        queue_pose(make_pose(63'd1000, 0, 0, 0, 0, 0, 0, 32'sh4000_0000), 0);
        queue_pose(make_pose(63'd1000, 65536, 0, 0, 0, 0, 0, 32'sh4000_0000), 0);
        queue_pose(make_pose(63'd1001000, 131072, 65536, -65536, 32'sh1000_0000, 0, 0,
                             32'sh3D00_0000), 0);
        queue_pose(make_pose(63'd500, 0, 0, 0, 0, 32'sh1000_0000, 0, 32'sh3D00_0000), 0);
        queue_pose(make_pose(63'd501, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                             0, 0, 32'sh4000_0000, 0), 0);
        queue_pose(make_pose(63'd502, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                             0, 0, 32'shC000_0000, 0), 0);
        queue_pose(make_pose(63'd503, 0, 0, 0, 0, 0, 0, 0), 0);
        queue_pose(make_pose(63'd20000000, 0, 0, 0, 0, 32'sh2000_0000, 0,
                             32'sh2000_0000), 0);
        queue_pose(make_pose(63'd40000000, 0, 0, 0, 0, 32'shE000_0000, 0,
                             32'sh2000_0000), 0);
        queue_pose(make_pose(63'h7FFF_FFFF_FFFF_FFFF, 5, -5, 7, 32'shC000_0000,
                             32'shC000_0000, 32'shC000_0000, 32'shC000_0000), 0);
        queue_pose(make_pose(63'd0, -7, 9, 11, 32'sh4000_0000, 32'sh4000_0000,
                             32'sh4000_0000, 32'sh4000_0000), 0);
        queue_pose(make_pose(63'd1, 0, 0, 0, 32'sh4000_0000, 0, 0, 0), 0);
        queue_pose(make_pose(63'd2, 0, 0, 0, 32'shC000_0000, 0, 0, 32'sh0000_0100), 0);
        queue_pose(make_pose(63'd3, 0, 0, 0, 32'sh4000_0000, 0, 0, -32'sh0000_0100), 0);
        queue_pose(make_pose(63'd4, 0, 0, 0, 0, 0, 0, 32'shC000_0000), 0);

        // Random: mostly steady tracks, some jumps, repeats and reversed stamps
        stamp = 63'd5000000;
        px = 0;
        py = 0;
        pz = 0;
        for (int n = 0; n < ITEM_COUNT; n++) begin
            kind = $urandom_range(19, 0);
            case (kind)
                0: stamp = 63'({$urandom, $urandom});
                1: stamp = stamp - 63'($urandom_range(100000000, 1));
                2: ;
                default: stamp = stamp + 63'($urandom_range(100000000, 1));
            endcase
            if (kind == 3) begin
                px = $urandom;
                py = $urandom;
                pz = $urandom;
            end
            else begin
                px = px + int'($urandom_range(200000, 0)) - 100000;
                py = py + int'($urandom_range(200000, 0)) - 100000;
                pz = pz + int'($urandom_range(2000, 0)) - 1000;
            end
            if (kind == 4)
                queue_pose(make_pose(stamp, px, py, pz, 0, 0, 0, 0), n == ITEM_COUNT / 2);
            else
                queue_pose(make_pose(stamp, px, py, pz, rand_quat(), rand_quat(),
                                     rand_quat(), rand_quat()), n == ITEM_COUNT / 2);
        end

        repeat (9) @(posedge clk);
        rst_n <= 1;

        wait (pose_jobs.size() == 0);
        @(posedge clk);
        while (pose_valid || rate_expected.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (rate_expected.size() != 0) mismatch_count++;

        $display("Covered %0d poses and %0d rate words, %0d with a zero interval,",
                 pose_accepted, rate_received, zero_rates_seen);
        $display("including reversed and repeated stamps, zero quaternions and gimbal lock.");
        if (mismatch_count == 0)
            $display("pose_difference_velocity_top regression: pass");
        else
            $display("pose_difference_velocity_top regression: fail");
        $finish;
    end

    // Bound the run in time
    initial begin
        #60ms;
        $display("pose_difference_velocity_top regression: fail");
        $finish;
    end

endmodule
